/* sv/matrix3_inverse_adjugate_top_macros.svh */
// Assertion macros for the 3x3 adjugate inverse block.
`ifndef MATRIX3_INVERSE_ADJUGATE_TOP_MACROS_SVH
`define MATRIX3_INVERSE_ADJUGATE_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define MI3_ASSERT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication
`define MI3_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define MI3_ASSERT(lbl, ck, rn, ante, cons)
`define MI3_ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif
`endif

/* sv/mi3_pkg.sv */
// Types and constants shared by the 3x3 adjugate inverse block.
package mi3_pkg;
	localparam int FRAC_BITS_DEF = 16;
	localparam int ELEM_W = 32;
	localparam int COF_W = 64;
	localparam int MAG_W = 63;
	localparam int DET_W = 98;
	localparam int DMAG_W = 97;
	localparam int QB = 33;
	localparam int LANES = 9;
	localparam int FRONT_LAT = 6;
	localparam int DIV_LAT = QB + 2;

	localparam logic [ELEM_W-1:0] ELEM_POS_MAX = 32'h7FFF_FFFF;
	localparam logic [ELEM_W-1:0] ELEM_NEG_MAX = 32'h8000_0000;

	typedef logic signed [ELEM_W-1:0] elem_t;
	typedef logic signed [COF_W-1:0] cof_t;
	typedef logic [MAG_W-1:0] mag_t;
	typedef logic [DMAG_W-1:0] dmag_t;

	typedef struct packed {
		elem_t col0_row0;
		elem_t col0_row1;
		elem_t col0_row2;
		elem_t col1_row0;
		elem_t col1_row1;
		elem_t col1_row2;
		elem_t col2_row0;
		elem_t col2_row1;
		elem_t col2_row2;
	} mat_t;

	typedef struct packed {
		elem_t inv_c0_r0;
		elem_t inv_c0_r1;
		elem_t inv_c0_r2;
		elem_t inv_c1_r0;
		elem_t inv_c1_r1;
		elem_t inv_c1_r2;
		elem_t inv_c2_r0;
		elem_t inv_c2_r1;
		elem_t inv_c2_r2;
		logic singular;
		logic saturated;
	} inv_t;

	// cofactor magnitudes and determinant, lane index = col*3 + row
	typedef struct packed {
		mag_t [LANES-1:0] amag;
		logic [LANES-1:0] aneg;
		dmag_t dmag;
		logic dneg;
		logic singular;
	} fdet_t;

	typedef struct packed {
		logic [LANES-1:0][ELEM_W-1:0] val;
		logic [LANES-1:0] sat;
	} dres_t;
endpackage

/* sv/mi3_front.sv */
// Cofactor and determinant pipeline: six register stages.
module mi3_front (
	input logic clk,
	input logic en,
	input mi3_pkg::mat_t mat,
	output mi3_pkg::fdet_t res
);
	import mi3_pkg::*;

	// cofactors at odd flat indexes carry a minus sign
	localparam logic [LANES-1:0] NEG_MASK = 9'b010101010;

	elem_t m [3][3];
	cof_t pa_s1 [LANES];
	cof_t pb_s1 [LANES];
	elem_t m0_s1 [3];
	cof_t adj_s2 [LANES];
	elem_t m0_s2 [3];
	logic signed [COF_W:0] plo_s3 [3];
	cof_t phi_s3 [3];
	cof_t adj_s3 [LANES];
	logic signed [DET_W-1:0] t_s4 [3];
	cof_t adj_s4 [LANES];
	logic signed [DET_W-1:0] det_s5;
	cof_t adj_s5 [LANES];
	fdet_t res_s6;

	function automatic cof_t mul32(elem_t a, elem_t b);
		return cof_t'(a) * cof_t'(b);
	endfunction

	always_comb begin
		m[0][0] = mat.col0_row0;
		m[0][1] = mat.col0_row1;
		m[0][2] = mat.col0_row2;
		m[1][0] = mat.col1_row0;
		m[1][1] = mat.col1_row1;
		m[1][2] = mat.col1_row2;
		m[2][0] = mat.col2_row0;
		m[2][1] = mat.col2_row1;
		m[2][2] = mat.col2_row2;
	end

	// stage 1: the eighteen 2x2 products
	always_ff @(posedge clk) begin
		if (en) begin
			pa_s1[0] <= mul32(m[1][1], m[2][2]); pb_s1[0] <= mul32(m[2][1], m[1][2]);
			pa_s1[3] <= mul32(m[1][0], m[2][2]); pb_s1[3] <= mul32(m[2][0], m[1][2]);
			pa_s1[6] <= mul32(m[1][0], m[2][1]); pb_s1[6] <= mul32(m[2][0], m[1][1]);
			pa_s1[1] <= mul32(m[0][1], m[2][2]); pb_s1[1] <= mul32(m[2][1], m[0][2]);
			pa_s1[4] <= mul32(m[0][0], m[2][2]); pb_s1[4] <= mul32(m[2][0], m[0][2]);
			pa_s1[7] <= mul32(m[0][0], m[2][1]); pb_s1[7] <= mul32(m[2][0], m[0][1]);
			pa_s1[2] <= mul32(m[0][1], m[1][2]); pb_s1[2] <= mul32(m[1][1], m[0][2]);
			pa_s1[5] <= mul32(m[0][0], m[1][2]); pb_s1[5] <= mul32(m[1][0], m[0][2]);
			pa_s1[8] <= mul32(m[0][0], m[1][1]); pb_s1[8] <= mul32(m[1][0], m[0][1]);
			for (int c = 0; c < 3; c++) begin
				m0_s1[c] <= m[c][0];
			end
		end
	end

	// stage 2: signed cofactors
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < LANES; k++) begin
				adj_s2[k] <= NEG_MASK[k] ? pb_s1[k] - pa_s1[k] : pa_s1[k] - pb_s1[k];
			end
			m0_s2 <= m0_s1;
		end
	end

	// stage 3: row-0 expansion, 32x64 split into two 32x32 halves
	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				plo_s3[c] <= (COF_W+1)'(m0_s2[c]) *
					(COF_W+1)'($signed({1'b0, adj_s2[c][31:0]}));
				phi_s3[c] <= cof_t'(m0_s2[c]) * cof_t'($signed(adj_s2[c][63:32]));
			end
			adj_s3 <= adj_s2;
		end
	end

	// stage 4: join halves
	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				t_s4[c] <= (DET_W'(phi_s3[c]) <<< 32) + DET_W'(plo_s3[c]);
			end
			adj_s4 <= adj_s3;
		end
	end

	// stage 5: determinant
	always_ff @(posedge clk) begin
		if (en) begin
			det_s5 <= t_s4[0] + t_s4[1] + t_s4[2];
			adj_s5 <= adj_s4;
		end
	end

	// stage 6: magnitudes and signs
	always_ff @(posedge clk) begin
		if (en) begin
			res_s6.dneg <= det_s5[DET_W-1];
			res_s6.dmag <= DMAG_W'(det_s5[DET_W-1] ? -det_s5 : det_s5);
			res_s6.singular <= (det_s5 == '0);
			for (int k = 0; k < LANES; k++) begin
				res_s6.aneg[k] <= adj_s5[k][COF_W-1];
				res_s6.amag[k] <= MAG_W'(adj_s5[k][COF_W-1] ? -adj_s5[k] : adj_s5[k]);
			end
		end
	end

	assign res = res_s6;
endmodule

/* sv/mi3_div.sv */
// Nine-lane restoring divider, one quotient bit per stage, with saturation.
module mi3_div #(
	parameter int FRAC_BITS = mi3_pkg::FRAC_BITS_DEF
) (
	input logic clk,
	input logic en,
	input mi3_pkg::fdet_t fd,
	output mi3_pkg::dres_t res
);
	import mi3_pkg::*;

	localparam int NUM_W = MAG_W + 2 * FRAC_BITS;
	localparam int CMP_W = DMAG_W + QB;
	localparam logic [QB-1:0] Q_POS_MAX = QB'(ELEM_POS_MAX);
	localparam logic [QB-1:0] Q_NEG_MAX = QB'(ELEM_NEG_MAX);

	logic [NUM_W-1:0] rem_s [LANES][QB+1];
	logic [QB-1:0] quo_s [LANES][QB+1];
	logic ovf_s [LANES][QB+1];
	logic neg_s [LANES][QB+1];
	dmag_t dmag_s [QB+1];
	dres_t out_s35;
	dres_t out_d;

	// entry: scale numerator, catch quotients of 2^QB or more
	always_ff @(posedge clk) begin
		if (en) begin
			dmag_s[0] <= fd.dmag;
			for (int l = 0; l < LANES; l++) begin
				rem_s[l][0] <= {fd.amag[l], {(2 * FRAC_BITS){1'b0}}};
				quo_s[l][0] <= '0;
				ovf_s[l][0] <= CMP_W'({fd.amag[l], {(2 * FRAC_BITS){1'b0}}}) >=
					{fd.dmag, {QB{1'b0}}};
				neg_s[l][0] <= fd.aneg[l] ^ fd.dneg;
			end
		end
	end

	// one quotient bit per stage, MSB first
	for (genvar k = 0; k < QB; k++) begin : g_step
		localparam int SH = QB - 1 - k;
		logic [CMP_W-1:0] cand;
		assign cand = CMP_W'(dmag_s[k]) << SH;

		always_ff @(posedge clk) begin
			if (en) begin
				dmag_s[k+1] <= dmag_s[k];
			end
		end

		for (genvar l = 0; l < LANES; l++) begin : g_lane
			logic ge;
			assign ge = CMP_W'(rem_s[l][k]) >= cand;

			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[l][k+1] <= ge ? rem_s[l][k] - cand[NUM_W-1:0] : rem_s[l][k];
					quo_s[l][k+1] <= quo_s[l][k] | (QB'(ge) << SH);
					ovf_s[l][k+1] <= ovf_s[l][k];
					neg_s[l][k+1] <= neg_s[l][k];
				end
			end
		end
	end

	// sign and clip
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			if (neg_s[l][QB]) begin
				out_d.sat[l] = ovf_s[l][QB] || (quo_s[l][QB] > Q_NEG_MAX);
				out_d.val[l] = out_d.sat[l] ? ELEM_NEG_MAX : -quo_s[l][QB][ELEM_W-1:0];
			end else begin
				out_d.sat[l] = ovf_s[l][QB] || (quo_s[l][QB] > Q_POS_MAX);
				out_d.val[l] = out_d.sat[l] ? ELEM_POS_MAX : quo_s[l][QB][ELEM_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_s35 <= out_d;
		end
	end

	assign res = out_s35;
endmodule

/* sv/matrix3_inverse_adjugate_top.sv */
// Top level of the 3x3 matrix inverse by adjugate, fully pipelined.
//
//  channel | valid     | ready     | payload
//  matrix  | mat_valid | mat_ready | mat (mi3_pkg::mat_t)
//  inverse | inv_valid | inv_ready | inv (mi3_pkg::inv_t)
//
// One item per cycle sustained while the output is not stalled; 6 cofactor/determinant
// stages, 35 divider stages (entry, 33 stages of one quotient bit each and
// the clip register), then the output register.
// Reset clears valid bits only. A stalled output is caught by a one-item
// skid register; mat_ready drops only while that register is full.
`include "matrix3_inverse_adjugate_top_macros.svh"
module matrix3_inverse_adjugate_top #(
	parameter int FRAC_BITS = mi3_pkg::FRAC_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic mat_valid,
	output logic mat_ready,
	input mi3_pkg::mat_t mat,
	output logic inv_valid,
	input logic inv_ready,
	output mi3_pkg::inv_t inv
);
	import mi3_pkg::*;

	localparam int PIPE_LAT = FRONT_LAT + DIV_LAT;

	logic en;
	logic [PIPE_LAT-1:0] vld_q;
	logic [DIV_LAT-1:0] sing_q;
	fdet_t fdet;
	dres_t dres;
	inv_t nxt;
	logic outv_q;
	logic skid_v_q;
	inv_t out_q;
	inv_t skid_q;
	logic sing_last;

	assign en = !skid_v_q;
	assign mat_ready = en;

	mi3_front u_front (
		.clk(clk),
		.en (en),
		.mat(mat),
		.res(fdet)
	);

	mi3_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk(clk),
		.en (en),
		.fd (fdet),
		.res(dres)
	);

	// valid bits follow the item through every stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[PIPE_LAT-2:0], mat_valid};
		end
	end

	// singular flag rides alongside the divider
	always_ff @(posedge clk) begin
		if (en) begin
			sing_q <= {sing_q[DIV_LAT-2:0], fdet.singular};
		end
	end

	assign sing_last = sing_q[DIV_LAT-1];

	// final result: zero all elements and the saturated flag on a singular matrix
	always_comb begin
		nxt.inv_c0_r0 = sing_last ? '0 : elem_t'(dres.val[0]);
		nxt.inv_c0_r1 = sing_last ? '0 : elem_t'(dres.val[1]);
		nxt.inv_c0_r2 = sing_last ? '0 : elem_t'(dres.val[2]);
		nxt.inv_c1_r0 = sing_last ? '0 : elem_t'(dres.val[3]);
		nxt.inv_c1_r1 = sing_last ? '0 : elem_t'(dres.val[4]);
		nxt.inv_c1_r2 = sing_last ? '0 : elem_t'(dres.val[5]);
		nxt.inv_c2_r0 = sing_last ? '0 : elem_t'(dres.val[6]);
		nxt.inv_c2_r1 = sing_last ? '0 : elem_t'(dres.val[7]);
		nxt.inv_c2_r2 = sing_last ? '0 : elem_t'(dres.val[8]);
		nxt.singular = sing_last;
		nxt.saturated = !sing_last && (|dres.sat);
	end

	// output register and skid control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outv_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (inv_ready) begin
				skid_v_q <= 1'b0;
			end
		end else if (!outv_q || inv_ready) begin
			outv_q <= vld_q[PIPE_LAT-1];
		end else if (vld_q[PIPE_LAT-1]) begin
			skid_v_q <= 1'b1;
		end
	end

	// output and skid data
	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (inv_ready) begin
				out_q <= skid_q;
			end
		end else if (!outv_q || inv_ready) begin
			out_q <= nxt;
		end else begin
			skid_q <= nxt;
		end
	end

	assign inv_valid = outv_q;
	assign inv = out_q;

	`MI3_ASSERT(a_skid_has_out, clk, arst_n, skid_v_q, outv_q)
	`MI3_ASSERT(a_sing_zero, clk, arst_n, inv_valid && inv.singular, !inv.saturated && inv.inv_c0_r0 == '0 && inv.inv_c2_r2 == '0)
	`MI3_ASSERT_NEXT(a_skid_catch, clk, arst_n, outv_q && !inv_ready && !skid_v_q && vld_q[PIPE_LAT-1], skid_v_q)
endmodule

/* bench/tb_matrix3_inverse_adjugate_top.sv */
// Testbench for the 3x3 adjugate matrix inverse: random and directed matrices, exact predictor.
module tb_matrix3_inverse_adjugate_top;
	timeunit 1ns;
	timeprecision 1ps;
	import mi3_pkg::*;

	localparam int FRAC = 16;
	localparam int LAT = 42;

	// Exact inverse predictor; cofactors fit 64 bits, determinant 98, numerator 95
	function automatic inv_t invert_matrix(mat_t a);
		logic signed [31:0] e [3][3];
		logic signed [65:0] adj [3][3];
		logic signed [127:0] det, num, q, dmag;
		logic dneg, qneg;
		inv_t o;
		logic [31:0] v [9];
		e[0][0] = a.col0_row0; e[0][1] = a.col0_row1; e[0][2] = a.col0_row2;
		e[1][0] = a.col1_row0; e[1][1] = a.col1_row1; e[1][2] = a.col1_row2;
		e[2][0] = a.col2_row0; e[2][1] = a.col2_row1; e[2][2] = a.col2_row2;
		adj[0][0] =  (66'(e[1][1]) * e[2][2] - 66'(e[2][1]) * e[1][2]);
		adj[1][0] = -(66'(e[1][0]) * e[2][2] - 66'(e[2][0]) * e[1][2]);
		adj[2][0] =  (66'(e[1][0]) * e[2][1] - 66'(e[2][0]) * e[1][1]);
		adj[0][1] = -(66'(e[0][1]) * e[2][2] - 66'(e[2][1]) * e[0][2]);
		adj[1][1] =  (66'(e[0][0]) * e[2][2] - 66'(e[2][0]) * e[0][2]);
		adj[2][1] = -(66'(e[0][0]) * e[2][1] - 66'(e[2][0]) * e[0][1]);
		adj[0][2] =  (66'(e[0][1]) * e[1][2] - 66'(e[1][1]) * e[0][2]);
		adj[1][2] = -(66'(e[0][0]) * e[1][2] - 66'(e[1][0]) * e[0][2]);
		adj[2][2] =  (66'(e[0][0]) * e[1][1] - 66'(e[1][0]) * e[0][1]);
		det = 128'(e[0][0]) * 128'(adj[0][0]) + 128'(e[1][0]) * 128'(adj[0][1])
			+ 128'(e[2][0]) * 128'(adj[0][2]);
		o = '0;
		if (det == 0) begin
			o.singular = 1'b1;
			return o;
		end
		dneg = det < 0;
		dmag = dneg ? -det : det;
		for (int c = 0; c < 3; c++) begin
			for (int r = 0; r < 3; r++) begin
				qneg = (adj[c][r] < 0) != dneg;
				num = 128'(adj[c][r] < 0 ? -adj[c][r] : adj[c][r]);
				num = num <<< (2 * FRAC);
				q = num / dmag;
				if (!qneg) begin
					if (q > 128'sh7FFF_FFFF) begin
						v[c*3+r] = ELEM_POS_MAX; o.saturated = 1'b1;
					end else v[c*3+r] = q[31:0];
				end else begin
					if (q > 128'sh8000_0000) begin
						v[c*3+r] = ELEM_NEG_MAX; o.saturated = 1'b1;
					end else v[c*3+r] = 32'(-q);
				end
			end
		end
		o.inv_c0_r0 = v[0]; o.inv_c0_r1 = v[1]; o.inv_c0_r2 = v[2];
		o.inv_c1_r0 = v[3]; o.inv_c1_r1 = v[4]; o.inv_c1_r2 = v[5];
		o.inv_c2_r0 = v[6]; o.inv_c2_r1 = v[7]; o.inv_c2_r2 = v[8];
		return o;
	endfunction

	// Holds predicted inverses in order and compares arriving ones
	class inverse_scoreboard;
		inv_t pending[$];
		int mismatches = 0;

		function void note_matrix(mat_t a);
			pending.push_back(invert_matrix(a));
		endfunction

		function void check_inverse(inv_t got);
			inv_t want;
			if (pending.size() == 0) begin
				report(got, 'x, "unexpected inverse");
				return;
			end
			want = pending.pop_front();
			if (got !== want) report(got, want, "inverse mismatch");
		endfunction

		function void report(inv_t got, inv_t want, string what);
			mismatches++;
			if (mismatches <= 10)
				$display("%s: expected %h actual %h", what, want, got);
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic mat_valid = 0;
	logic mat_ready;
	mat_t mat = '0;
	logic inv_valid;
	logic inv_ready = 0;
	inv_t inv;

	inverse_scoreboard sb = new();
	bit calm = 0;
	bit hold_off = 0;

	matrix3_inverse_adjugate_top u_top (
		.clk(clk), .arst_n(arst_n), .mat_valid(mat_valid), .mat_ready(mat_ready),
		.mat(mat), .inv_valid(inv_valid), .inv_ready(inv_ready), .inv(inv)
	);

	always #5 clk = ~clk;

	// Sample both handshakes at the rising edge
	always @(posedge clk) begin
		if (arst_n && mat_valid && mat_ready) sb.note_matrix(mat);
		if (arst_n && inv_valid && inv_ready) sb.check_inverse(inv);
	end

	function automatic logic [31:0] rand_elem();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			2: return 32'($signed($urandom_range(0, 64)) - 32) <<< 16;
			3: return $urandom_range(0, 3) == 0 ? 32'h0 : 32'($signed($urandom_range(0, 8)) - 4);
			default: return 32'($signed($urandom_range(0, 131072)) - 65536) <<< $urandom_range(0, 16);
		endcase
	endfunction

	function automatic mat_t rand_matrix();
		mat_t a;
		logic [31:0] s;
		for (int i = 0; i < 9; i++) a[i*32 +: 32] = rand_elem();
		// Dependent rows/columns make singular cases common
		case ($urandom_range(0, 9))
			0: begin
				a.col2_row0 = a.col0_row0; a.col2_row1 = a.col0_row1;
				a.col2_row2 = a.col0_row2;
			end
			1: begin
				s = $urandom_range(0, 1) ? 32'h0 : $urandom;
				a.col0_row1 = s; a.col1_row1 = s; a.col2_row1 = s;
			end
			default: ;
		endcase
		return a;
	endfunction

	// Offer one matrix, with an optional burst of idle cycles before it
	task automatic send_matrix(mat_t a);
		if (!calm && $urandom_range(0, 3) == 0) begin
			mat_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end
		mat <= a;
		mat_valid <= 1'b1;
		@(posedge clk);
		while (!mat_ready) @(posedge clk);
		@(negedge clk);
	endtask

	// Receiver: random stall bursts, plus one long hold-off
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) begin
				inv_ready <= 1'b0;
				repeat (200) @(negedge clk);
				hold_off = 0;
			end
			if (!calm && $urandom_range(0, 3) == 0) begin
				inv_ready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(negedge clk);
			end
			inv_ready <= 1'b1;
		end
	end

	// Stimulus and end of run
	initial begin
		mat_t a;
		repeat (3) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		// Directed: identity, scaled identity, zeros, extremes, tiny determinant
		a = '0; a.col0_row0 = 32'h1_0000; a.col1_row1 = 32'h1_0000; a.col2_row2 = 32'h1_0000;
		send_matrix(a);
		a.col0_row0 = 32'h2_0000; a.col1_row1 = 32'hFFFE_0000; a.col2_row2 = 32'h0_8000;
		send_matrix(a);
		send_matrix('0);
		send_matrix({9{32'h7FFF_FFFF}});
		send_matrix({9{32'h8000_0000}});
		a = '0; a.col0_row0 = 1; a.col1_row1 = 1; a.col2_row2 = 1;
		send_matrix(a);
		a.col2_row2 = 32'hFFFF_FFFF;
		send_matrix(a);
		a = '0; a.col0_row0 = 32'h7FFF_FFFF; a.col1_row1 = 32'h8000_0000;
		a.col2_row2 = 32'h7FFF_FFFF;
		send_matrix(a);
		a = '0; a.col0_row1 = 32'h8000_0000; a.col1_row2 = 32'h8000_0000;
		a.col2_row0 = 32'h8000_0000;
		send_matrix(a);
		a = {32'h1_0000, 32'h2_0000, 32'h3_0000, 32'h0, 32'h1_0000, 32'h4_0000,
			32'h5_0000, 32'h6_0000, 32'h0};
		send_matrix(a);
		send_matrix({9{32'hFFFF_FFFF}});
		send_matrix({9{32'h5555_5555}});
		send_matrix({9{32'hAAAA_AAAA}});
		for (int i = 0; i < 1500; i++) begin
			if (i == 300) hold_off = 1;
			if (i == 1300) calm = 1;
			send_matrix(rand_matrix());
		end
		mat_valid <= 1'b0;
		wait (sb.pending.size() == 0);
		repeat (LAT + 10) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#2ms;
		$display("Verification failed");
		$finish;
	end
endmodule
